>>> rtl/edfh_pkg.sv
// shared types and constants for the effective diameter block
package edfh_pkg;

	localparam int DIST_W         = 8;
	localparam int PCT_W          = 17;
	localparam int PCT_FRAC       = 16;
	localparam int Q_FRAC         = 8;
	localparam int OUT_W          = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 17;
	localparam int MAX_BINS_DEF   = 256;
	localparam int COUNT_BITS_DEF = 40;

	localparam int MUL_CNT_W = $clog2(PCT_W);
	localparam int DIV_CNT_W = $clog2(OUT_W);

	localparam logic [PCT_W-1:0] PCT_ONE   = PCT_W'(65536);
	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(58982);
	localparam logic [OUT_W-1:0] ONE_Q88   = OUT_W'(256);

	localparam logic [DIV_CNT_W-1:0] EFF_DIV_LAST = DIV_CNT_W'(Q_FRAC - 1);
	localparam logic [DIV_CNT_W-1:0] AVG_DIV_LAST = DIV_CNT_W'(OUT_W - 1);
	localparam logic [MUL_CNT_W-1:0] MUL_TOP      = MUL_CNT_W'(PCT_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_PERCENTILE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CUMULATIVE = CFG_IDX_W'(1);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_MUL,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_DIV_EFF,
		ST_EFF_WR,
		ST_AVG,
		ST_DIV_AVG,
		ST_AVG_WR,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_START,
		OP_MUL_STEP,
		OP_SCAN_NEXT,
		OP_EFF_FIRST,
		OP_EFF_DIST,
		OP_EFF_LAST,
		OP_DIV_EFF,
		OP_DIV_STEP,
		OP_EFF_DIV,
		OP_AVG_START,
		OP_AVG_DIV,
		OP_AVG_SAT,
		OP_AVG_NONE,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic hit;
		logic first;
		logic scan_last;
		logic step_zero;
		logic mul_done;
		logic div_done;
		logic avg_en;
		logic avg_sat;
	} dp_status_t;

endpackage

>>> rtl/edfh_datapath.sv
// bin store, accumulators, shift-add multiplier, fraction divider and result registers
module edfh_datapath #(
	parameter int MAX_BINS   = edfh_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = edfh_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  edfh_pkg::dp_op_t                  op,
	output edfh_pkg::dp_status_t              status,
	input  logic                              cfg_valid,
	input  logic [edfh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [edfh_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [edfh_pkg::DIST_W-1:0]       distance,
	input  logic [COUNT_BITS-1:0]             pair_count,
	output logic [edfh_pkg::OUT_W-1:0]        effective_diameter,
	output logic [edfh_pkg::OUT_W-1:0]        average_diameter,
	output logic                              average_valid
);
	import edfh_pkg::*;

	localparam int AW = $clog2(MAX_BINS);
	localparam int BW = $clog2(MAX_BINS + 1);
	localparam int CW = COUNT_BITS;
	localparam int WW = COUNT_BITS + Q_FRAC;
	localparam int TW = COUNT_BITS + PCT_FRAC;
	localparam int MW = DIST_W + COUNT_BITS;

	logic [MW-1:0] mem [MAX_BINS];
	logic [MW-1:0] rd_q;

	logic [PCT_W-1:0]     pct_q;
	logic                 cum_mode_q;
	logic [BW-1:0]        bins_q;
	logic [CW-1:0]        total_q;
	logic [WW-1:0]        wsum_q;
	logic [DIST_W-1:0]    last_dist_q;
	logic [TW-1:0]        target_q;
	logic [MUL_CNT_W-1:0] mul_cnt_q;
	logic [AW-1:0]        idx_q;
	logic [CW-1:0]        prev_cum_q;
	logic [DIST_W-1:0]    prev_dist_q;
	logic [TW-1:0]        rem_q;
	logic [TW-1:0]        den_q;
	logic [OUT_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [OUT_W-1:0]     eff_q;
	logic [OUT_W-1:0]     avg_q;
	logic                 avg_ok_q;
	logic [OUT_W-1:0]     eff_out_q;
	logic [OUT_W-1:0]     avg_out_q;
	logic                 avg_ok_out_q;

	logic [CW:0]          sum_c;
	logic [WW-1:0]        prod_c;
	logic [WW:0]          wsum_sum_c;
	logic [CW-1:0]        new_total_c;
	logic [WW-1:0]        new_wsum_c;
	logic                 store_c;
	logic [CW-1:0]        rd_cum;
	logic [DIST_W-1:0]    rd_dist;
	logic [TW:0]          r2_c;
	logic [TW:0]          diff_c;
	logic                 ge_c;

	assign rd_cum  = rd_q[CW-1:0];
	assign rd_dist = rd_q[MW-1:CW];

	// bin load: pdf counts are summed, cdf counts taken as they are
	assign sum_c       = {1'b0, total_q} + {1'b0, pair_count};
	assign prod_c      = WW'(distance) * WW'(pair_count);
	assign wsum_sum_c  = {1'b0, wsum_q} + {1'b0, prod_c};
	assign new_total_c = cum_mode_q ? pair_count : (sum_c[CW] ? '1 : sum_c[CW-1:0]);
	assign new_wsum_c  = cum_mode_q ? wsum_q : (wsum_sum_c[WW] ? '1 : wsum_sum_c[WW-1:0]);
	assign store_c     = (op == OP_LOAD) && (bins_q < BW'(MAX_BINS));

	// one restoring step of the fraction divider
	assign r2_c   = {rem_q, 1'b0};
	assign diff_c = r2_c - {1'b0, den_q};
	assign ge_c   = r2_c >= {1'b0, den_q};

	always_comb begin
		status.hit       = {rd_cum, {PCT_FRAC{1'b0}}} > target_q;
		status.first     = idx_q == '0;
		status.scan_last = (BW'(idx_q) + BW'(1)) == bins_q;
		status.step_zero = rd_cum <= prev_cum_q;
		status.mul_done  = mul_cnt_q == '0;
		status.div_done  = div_cnt_q == '0;
		status.avg_en    = !cum_mode_q && (total_q != '0);
		status.avg_sat   = wsum_q >= {total_q, {Q_FRAC{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (store_c) begin
			mem[bins_q[AW-1:0]] <= {distance, new_total_c};
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q      <= PCT_RESET;
			cum_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERCENTILE: begin
					pct_q <= (cfg_data > PCT_ONE) ? PCT_ONE : cfg_data;
				end
				REG_CUMULATIVE: begin
					cum_mode_q <= cfg_data[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q    <= '0;
			total_q   <= '0;
			wsum_q    <= '0;
			mul_cnt_q <= '0;
			div_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			unique case (op)
				OP_LOAD: begin
					if (store_c) begin
						bins_q  <= bins_q + BW'(1);
						total_q <= new_total_c;
						wsum_q  <= new_wsum_c;
					end
				end
				OP_MUL_START: begin
					mul_cnt_q <= MUL_TOP;
					idx_q     <= '0;
				end
				OP_MUL_STEP: begin
					mul_cnt_q <= mul_cnt_q - MUL_CNT_W'(1);
				end
				OP_SCAN_NEXT: begin
					idx_q <= idx_q + AW'(1);
				end
				OP_DIV_EFF: begin
					div_cnt_q <= EFF_DIV_LAST;
				end
				OP_AVG_START: begin
					div_cnt_q <= AVG_DIV_LAST;
				end
				OP_DIV_STEP: begin
					div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
				end
				OP_FINISH: begin
					bins_q  <= '0;
					total_q <= '0;
					wsum_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (store_c) begin
					last_dist_q <= distance;
				end
			end
			OP_MUL_START: begin
				target_q <= '0;
			end
			OP_MUL_STEP: begin
				// msb-first shift-add of percentile times total
				target_q <= {target_q[TW-2:0], 1'b0} + (pct_q[mul_cnt_q] ? TW'(total_q) : '0);
			end
			OP_SCAN_NEXT: begin
				prev_cum_q  <= rd_cum;
				prev_dist_q <= rd_dist;
			end
			OP_EFF_FIRST: begin
				eff_q <= ONE_Q88;
			end
			OP_EFF_DIST: begin
				eff_q <= {rd_dist, {Q_FRAC{1'b0}}};
			end
			OP_EFF_LAST: begin
				eff_q <= {last_dist_q, {Q_FRAC{1'b0}}};
			end
			OP_DIV_EFF: begin
				rem_q <= target_q - {prev_cum_q, {PCT_FRAC{1'b0}}};
				den_q <= {rd_cum - prev_cum_q, {PCT_FRAC{1'b0}}};
				quo_q <= '0;
			end
			OP_AVG_START: begin
				// quotient below 256 here, so 16 fraction steps over total * 256
				rem_q <= TW'(wsum_q);
				den_q <= TW'({total_q, {Q_FRAC{1'b0}}});
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				rem_q <= ge_c ? diff_c[TW-1:0] : r2_c[TW-1:0];
				quo_q <= {quo_q[OUT_W-2:0], ge_c};
			end
			OP_EFF_DIV: begin
				eff_q <= {prev_dist_q, quo_q[Q_FRAC-1:0]};
			end
			OP_AVG_DIV: begin
				avg_q    <= quo_q;
				avg_ok_q <= 1'b1;
			end
			OP_AVG_SAT: begin
				avg_q    <= '1;
				avg_ok_q <= 1'b1;
			end
			OP_AVG_NONE: begin
				avg_q    <= '0;
				avg_ok_q <= 1'b0;
			end
			OP_FINISH: begin
				eff_out_q    <= eff_q;
				avg_out_q    <= avg_q;
				avg_ok_out_q <= avg_ok_q;
			end
			default: begin
			end
		endcase
	end

	assign effective_diameter = eff_out_q;
	assign average_diameter   = avg_out_q;
	assign average_valid      = avg_ok_out_q;

	a_bins_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		bins_q <= BW'(MAX_BINS))
		else $error("bin count beyond store depth");

	a_div_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_DIV_STEP) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_interp_from_below: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_DIV_EFF) |-> ({prev_cum_q, {PCT_FRAC{1'b0}}} <= target_q))
		else $error("interpolation starts above target");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FINISH) |=> (bins_q == '0) && (total_q == '0))
		else $error("accumulators not cleared after result");

endmodule

>>> rtl/edfh_ctrl.sv
// sequencer for load, multiply, scan, divide and result handoff
module edfh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  last_bin,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  edfh_pkg::dp_status_t  status,
	output edfh_pkg::dp_op_t      op
);
	import edfh_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op = OP_LOAD;
					if (last_bin) begin
						state_d = ST_START;
					end
				end
			end
			ST_START: begin
				op      = OP_MUL_START;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				op = OP_MUL_STEP;
				if (status.mul_done) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				// store read latency
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				priority if (status.hit && status.first) begin
					op      = OP_EFF_FIRST;
					state_d = ST_AVG;
				end else if (status.hit && status.step_zero) begin
					op      = OP_EFF_DIST;
					state_d = ST_AVG;
				end else if (status.hit) begin
					op      = OP_DIV_EFF;
					state_d = ST_DIV_EFF;
				end else if (status.scan_last) begin
					op      = OP_EFF_LAST;
					state_d = ST_AVG;
				end else begin
					op      = OP_SCAN_NEXT;
					state_d = ST_SCAN_RD;
				end
			end
			ST_DIV_EFF: begin
				op = OP_DIV_STEP;
				if (status.div_done) begin
					state_d = ST_EFF_WR;
				end
			end
			ST_EFF_WR: begin
				op      = OP_EFF_DIV;
				state_d = ST_AVG;
			end
			ST_AVG: begin
				priority if (!status.avg_en) begin
					op      = OP_AVG_NONE;
					state_d = ST_DONE;
				end else if (status.avg_sat) begin
					op      = OP_AVG_SAT;
					state_d = ST_DONE;
				end else begin
					op      = OP_AVG_START;
					state_d = ST_DIV_AVG;
				end
			end
			ST_DIV_AVG: begin
				op = OP_DIV_STEP;
				if (status.div_done) begin
					state_d = ST_AVG_WR;
				end
			end
			ST_AVG_WR: begin
				op      = OP_AVG_DIV;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// wait until the output register is free
				if (!out_valid_q || out_ready) begin
					op      = OP_FINISH;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_FINISH) |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CMP) |-> ($past(state_q) == ST_SCAN_RD))
		else $error("scan compare without store read");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result shown outside handoff");

	a_no_load_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_LOAD) |-> (state_q == ST_LOAD) && in_valid)
		else $error("bin loaded outside load phase");

endmodule

>>> rtl/effective_diameter_from_histogram.sv
// top level of the effective diameter block
//
// Bins of a hop-distance histogram come in on the in channel (in_valid/in_ready), one
// request per bin: distance, pair_count and last_bin. While the block is loading, bins
// are taken at one per cycle into a block memory, with running CDF and weighted distance
// sums kept alongside. The request marked last_bin closes the histogram. The block then
// stops taking bins and works out the result: setup, shift-add for percentile times
// total, a scan of the bins (memory read, then compare, for each bin scanned), fraction
// division for the interpolation where needed, the average decision and division for
// the mean where needed, then the handoff of the result. The run time is set by the
// scan through the memory port and the bit-serial divider.
// The result (effective_diameter, average_diameter, average_valid) sits in an output
// register on the out channel (out_valid/out_ready). Loading of the next histogram
// starts at once; if the receiver stalls, only the next histogram's handoff waits.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes percentile
// (index 0) or counts_are_cumulative (index 1); it is always ready.
// Reset empties the histogram, drops any pending result and restores the defaults
// of both configuration registers. The bin memory needs no clearing pass.
module effective_diameter_from_histogram #(
	parameter int MAX_BINS   = edfh_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = edfh_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [edfh_pkg::DIST_W-1:0]       distance,
	input  logic [COUNT_BITS-1:0]             pair_count,
	input  logic                              last_bin,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [edfh_pkg::OUT_W-1:0]        effective_diameter,
	output logic [edfh_pkg::OUT_W-1:0]        average_diameter,
	output logic                              average_valid,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [edfh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [edfh_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import edfh_pkg::*;

	dp_status_t status;
	dp_op_t     op;

	assign cfg_ready = 1'b1;

	edfh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.last_bin  (last_bin),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	edfh_datapath #(
		.MAX_BINS   (MAX_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.op                 (op),
		.status             (status),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.distance           (distance),
		.pair_count         (pair_count),
		.effective_diameter (effective_diameter),
		.average_diameter   (average_diameter),
		.average_valid      (average_valid)
	);

endmodule
